// ===== design/kce_pkg.sv =====
`default_nettype none
package kce_pkg;

	// request opcodes
	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_EVAL  = 1'b1;

	// segment modes; the reserved code holds like constant
	localparam logic [1:0] MODE_CUBIC  = 2'd0;
	localparam logic [1:0] MODE_CONST  = 2'd1;
	localparam logic [1:0] MODE_LINEAR = 2'd2;
	localparam logic [1:0] MODE_RSVD   = 2'd3;

	// configuration register index
	localparam logic REG_KEY_COUNT = 1'b0;

	// request queue between front and back
	localparam int QDEPTH = 4;
	localparam int QAW    = 2;

	// one keyframe table entry
	typedef struct packed {
		logic [31:0] key_time;
		logic [31:0] key_value;
		logic [31:0] tangent_out;
		logic [31:0] tangent_in;
		logic [1:0]  interp_mode;
	} kce_key_t;

	// one classified request
	typedef struct packed {
		logic        is_write;
		logic        write_ok;
		logic [5:0]  key_index;
		kce_key_t    key;
		logic [31:0] query_time;
	} kce_item_t;

	// back-end states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RD0,
		ST_RDL,
		ST_CHK,
		ST_SRCH,
		ST_RDS,
		ST_CAPS,
		ST_PREP,
		ST_DIV,
		ST_POLY,
		ST_SQ,
		ST_CU,
		ST_WGT,
		ST_MAC,
		ST_FIN
	} kce_state_t;

endpackage
`default_nettype wire

// ===== design/kce_ram.sv =====
`default_nettype none
module kce_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

// ===== design/kce_front.sv =====
`default_nettype none
module kce_front import kce_pkg::*; #(
	parameter int MAX_KEYS = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        opcode,
	input  wire logic [5:0]  key_index,
	input  wire logic [31:0] key_time,
	input  wire logic [31:0] key_value,
	input  wire logic [31:0] tangent_out,
	input  wire logic [31:0] tangent_in,
	input  wire logic [1:0]  interp_mode,
	input  wire logic [31:0] query_time,
	output kce_item_t        item,
	output logic             item_valid,
	input  wire logic        item_pop
);

	kce_item_t      q_mem_q [QDEPTH];
	logic [QAW-1:0] wr_ptr_q, rd_ptr_q;
	logic [QAW:0]   count_q;
	kce_item_t      cls;
	logic           push;

	// classify the incoming request
	always_comb begin
		cls                  = '0;
		cls.is_write         = (opcode == OP_WRITE);
		cls.write_ok         = (32'(key_index) < 32'(MAX_KEYS));
		cls.key_index        = key_index;
		cls.key.key_time     = key_time;
		cls.key.key_value    = key_value;
		cls.key.tangent_out  = tangent_out;
		cls.key.tangent_in   = tangent_in;
		cls.key.interp_mode  = interp_mode;
		cls.query_time       = query_time;
	end

	assign in_stall   = (count_q == (QAW+1)'(QDEPTH));
	assign push       = in_valid && !in_stall;
	assign item_valid = (count_q != '0);
	assign item       = q_mem_q[rd_ptr_q];

	// queue payload
	always_ff @(posedge clk) begin
		if (push) begin
			q_mem_q[wr_ptr_q] <= cls;
		end
	end

	// queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (item_pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			unique case ({push, item_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (QAW+1)'(QDEPTH))
		else $error("request queue overflow");
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		item_pop |-> item_valid)
		else $error("pop from empty request queue");
	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_ptr_q - rd_ptr_q) == count_q[QAW-1:0])
		else $error("queue pointers disagree with count");

endmodule
`default_nettype wire

// ===== design/kce_back.sv =====
`default_nettype none
module kce_back import kce_pkg::*; #(
	parameter int MAX_KEYS  = 64,
	parameter int FRAC_BITS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  kce_item_t        item,
	input  wire logic        item_valid,
	output logic             item_pop,
	input  wire logic [6:0]  key_count,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [31:0]      curve_value,
	output logic [5:0]       segment_used,
	output logic             clamped,
	output logic             saturated
);

	localparam int AW  = $clog2(MAX_KEYS);
	localparam int UW  = FRAC_BITS + 1;
	localparam int WW  = FRAC_BITS + 4;
	localparam int PW  = 32 + WW;
	localparam int ACW = PW + 3;
	localparam int DCW = $clog2(FRAC_BITS + 1);
	localparam logic [UW-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

	kce_state_t state_q, state_d;

	// table memory
	logic          ram_we;
	logic [AW-1:0] ram_waddr, ram_raddr;
	kce_key_t      ram_rdata;
	logic [31:0]   widx32;

	assign widx32    = 32'(item.key_index);
	assign ram_waddr = widx32[AW-1:0];

	kce_ram #(.WIDTH($bits(kce_key_t)), .DEPTH(MAX_KEYS)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (item.key),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// last key in use, count clamped to 1..MAX_KEYS
	logic [31:0]   kc32, last32;
	logic [AW-1:0] last_idx;
	always_comb begin
		kc32 = 32'(key_count);
		if (kc32 == 32'd0) last32 = 32'd0;
		else if (kc32 > 32'(MAX_KEYS)) last32 = 32'(MAX_KEYS) - 32'd1;
		else last32 = kc32 - 32'd1;
		last_idx = last32[AW-1:0];
	end

	// datapath registers
	logic signed [31:0]  q_q, t0_q, v0_q, t1_q, v1_q, t2_q, v2_q, mo1_q, mi2_q;
	logic [1:0]          mode_q;
	logic [AW-1:0]       idx_q, pidx_q, seg_q;
	logic                sv_q, clamp_q;
	logic signed [32:0]  dt_q;
	logic [33:0]         rem_q;
	logic [UW-1:0]       u_q, s2_q, s3_q;
	logic [DCW-1:0]      dcnt_q;
	logic signed [WW-1:0] w_q [4];
	logic [2:0]          k_q;
	logic signed [PW-1:0]  prod_q;
	logic signed [ACW-1:0] acc_q;
	logic                ovalid_q;

	// combinational helpers
	logic signed [32:0]  dt_c, du_c;
	logic [33:0]         rem2;
	logic                div_bit;
	logic [2*UW-1:0]     sq_c, cu_c;
	logic [UW-1:0]       s2_c, s3_c;
	logic signed [WW-1:0] s2e, s3e, ue, onee;
	logic signed [31:0]  op_a;
	logic signed [WW-1:0] op_w;
	logic signed [ACW-1:0] rnd_c, sh_c;
	logic signed [31:0]  res_c;
	logic                sat_c, hit, load_out;
	logic [31:0]         seg32;

	assign dt_c = 33'(t2_q) - 33'(t1_q);
	assign du_c = 33'(q_q) - 33'(t1_q);
	assign rem2 = {rem_q[32:0], 1'b0};
	assign div_bit = (rem2 >= {1'b0, dt_q});

	// squares and cubes rounded half up
	assign sq_c = (2*UW)'(u_q) * (2*UW)'(u_q) + (2*UW)'(1'b1 << (FRAC_BITS - 1));
	assign s2_c = UW'(sq_c >> FRAC_BITS);
	assign cu_c = (2*UW)'(s2_q) * (2*UW)'(u_q) + (2*UW)'(1'b1 << (FRAC_BITS - 1));
	assign s3_c = UW'(cu_c >> FRAC_BITS);

	assign s2e  = WW'(s2_q);
	assign s3e  = WW'(s3_q);
	assign ue   = WW'(u_q);
	assign onee = WW'(ONE);

	// multiply-accumulate operand select
	always_comb begin
		unique case (k_q[1:0])
			2'd0: op_a = v1_q;
			2'd1: op_a = v2_q;
			2'd2: op_a = mo1_q;
			default: op_a = mi2_q;
		endcase
		op_w = w_q[k_q[1:0]];
	end

	// final rounding and saturation
	always_comb begin
		rnd_c = acc_q + ACW'(1'b1 << (FRAC_BITS - 1));
		sh_c  = rnd_c >>> FRAC_BITS;
		sat_c = 1'b0;
		res_c = sh_c[31:0];
		if (sh_c > ACW'(32'sh7fffffff)) begin
			res_c = 32'sh7fffffff;
			sat_c = 1'b1;
		end else if (sh_c < -ACW'(33'sh080000000)) begin
			res_c = 32'sh80000000;
			sat_c = 1'b1;
		end
	end

	assign hit      = sv_q && ($signed(ram_rdata.key_time) > q_q);
	assign load_out = (state_q == ST_FIN) && (!ovalid_q || !out_stall);
	assign seg32    = 32'(seg_q);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (item_valid && !item.is_write) state_d = ST_RD0;
			ST_RD0:  state_d = ST_RDL;
			ST_RDL:  state_d = ST_CHK;
			ST_CHK: begin
				if (q_q < t0_q || q_q >= $signed(ram_rdata.key_time)) state_d = ST_FIN;
				else state_d = ST_SRCH;
			end
			ST_SRCH: if (hit) state_d = ST_RDS;
			ST_RDS:  state_d = ST_CAPS;
			ST_CAPS: state_d = ST_PREP;
			ST_PREP: begin
				if ((mode_q != MODE_CUBIC && mode_q != MODE_LINEAR) || dt_c <= 0 || du_c < 0)
					state_d = ST_FIN;
				else if (du_c >= dt_c) state_d = ST_POLY;
				else state_d = ST_DIV;
			end
			ST_DIV:  if (dcnt_q == DCW'(1)) state_d = ST_POLY;
			ST_POLY: state_d = (mode_q == MODE_LINEAR) ? ST_MAC : ST_SQ;
			ST_SQ:   state_d = ST_CU;
			ST_CU:   state_d = ST_WGT;
			ST_WGT:  state_d = ST_MAC;
			ST_MAC:  if (k_q == 3'd4) state_d = ST_FIN;
			ST_FIN:  if (load_out) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		item_pop  = (state_q == ST_IDLE) && item_valid;
		ram_we    = item_pop && item.is_write && item.write_ok;
		ram_raddr = '0;
		unique case (state_q)
			ST_RDL:  ram_raddr = last_idx;
			ST_SRCH: ram_raddr = idx_q;
			ST_RDS:  ram_raddr = seg_q;
			default: ram_raddr = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			ovalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_out) ovalid_q <= 1'b1;
			else if (!out_stall) ovalid_q <= 1'b0;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: q_q <= item.query_time;
			ST_RDL: begin
				t0_q <= ram_rdata.key_time;
				v0_q <= ram_rdata.key_value;
			end
			ST_CHK: begin
				if (q_q < t0_q) begin
					acc_q   <= ACW'(v0_q) <<< FRAC_BITS;
					seg_q   <= '0;
					clamp_q <= 1'b1;
				end else if (q_q >= $signed(ram_rdata.key_time)) begin
					acc_q   <= ACW'($signed(ram_rdata.key_value)) <<< FRAC_BITS;
					seg_q   <= last_idx;
					clamp_q <= (q_q > $signed(ram_rdata.key_time));
				end else begin
					clamp_q <= 1'b0;
				end
				idx_q <= AW'(1);
				sv_q  <= 1'b0;
			end
			ST_SRCH: begin
				idx_q  <= idx_q + 1'b1;
				pidx_q <= idx_q;
				sv_q   <= 1'b1;
				t2_q   <= ram_rdata.key_time;
				v2_q   <= ram_rdata.key_value;
				mi2_q  <= ram_rdata.tangent_in;
				seg_q  <= pidx_q - 1'b1;
			end
			ST_CAPS: begin
				t1_q   <= ram_rdata.key_time;
				v1_q   <= ram_rdata.key_value;
				mo1_q  <= ram_rdata.tangent_out;
				mode_q <= ram_rdata.interp_mode;
			end
			ST_PREP: begin
				dt_q   <= dt_c;
				rem_q  <= 34'(du_c);
				u_q    <= (du_c >= dt_c) ? ONE : '0;
				dcnt_q <= DCW'(FRAC_BITS);
				acc_q  <= ACW'(v1_q) <<< FRAC_BITS;
			end
			ST_DIV: begin
				rem_q  <= div_bit ? (rem2 - {1'b0, dt_q}) : rem2;
				u_q    <= {u_q[UW-2:0], div_bit};
				dcnt_q <= dcnt_q - 1'b1;
			end
			ST_POLY: begin
				w_q[0] <= onee - ue;
				w_q[1] <= ue;
				w_q[2] <= '0;
				w_q[3] <= '0;
				k_q    <= '0;
				acc_q  <= '0;
			end
			ST_SQ: s2_q <= s2_c;
			ST_CU: s3_q <= s3_c;
			ST_WGT: begin
				// Hermite basis weights
				w_q[0] <= WW'(onee - 3 * s2e + 2 * s3e);
				w_q[1] <= WW'(3 * s2e - 2 * s3e);
				w_q[2] <= WW'(ue - 2 * s2e + s3e);
				w_q[3] <= s3e - s2e;
			end
			ST_MAC: begin
				if (k_q != 3'd4) prod_q <= op_a * op_w;
				if (k_q != 3'd0) acc_q <= acc_q + ACW'(prod_q);
				k_q <= k_q + 1'b1;
			end
			ST_FIN: begin
				if (load_out) begin
					curve_value  <= res_c;
					saturated    <= sat_c;
					segment_used <= seg32[5:0];
					clamped      <= clamp_q;
				end
			end
			default: ;
		endcase
	end

	assign out_valid = ovalid_q;

	a_u_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_POLY) |-> (u_q <= ONE))
		else $error("segment fraction above one");
	a_load_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(ovalid_q) |-> $past(state_q == ST_FIN))
		else $error("result loaded outside final state");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(curve_value)))
		else $error("stalled result changed");

endmodule
`default_nettype wire

// ===== design/keyframe_curve_evaluator_top.sv =====
`default_nettype none
// Write request: the key table is written as the request is popped from the queue.
// Evaluate request: the key search reads one table entry per cycle through the single
// read port, and the segment fraction takes one quotient bit per cycle.
// One request is worked at a time; the front queue holds four more.
// Reset clears control state and sets key_count to 1; the key table is undefined until written.
module keyframe_curve_evaluator_top import kce_pkg::*; #(
	parameter int MAX_KEYS  = 64,
	parameter int FRAC_BITS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        opcode,
	input  wire logic [5:0]  key_index,
	input  wire logic [31:0] key_time,
	input  wire logic [31:0] key_value,
	input  wire logic [31:0] tangent_out,
	input  wire logic [31:0] tangent_in,
	input  wire logic [1:0]  interp_mode,
	input  wire logic [31:0] query_time,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [31:0]      curve_value,
	output logic [5:0]       segment_used,
	output logic             clamped,
	output logic             saturated,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	kce_item_t  item;
	logic       item_valid, item_pop;
	logic [6:0] key_count_q;

	// configuration register
	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_count_q <= 7'd1;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_KEY_COUNT) begin
			key_count_q <= pwdata[6:0];
		end
	end
	assign prdata = (paddr[2] == REG_KEY_COUNT) ? {25'd0, key_count_q} : 32'd0;

	kce_front #(.MAX_KEYS(MAX_KEYS)) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.opcode      (opcode),
		.key_index   (key_index),
		.key_time    (key_time),
		.key_value   (key_value),
		.tangent_out (tangent_out),
		.tangent_in  (tangent_in),
		.interp_mode (interp_mode),
		.query_time  (query_time),
		.item        (item),
		.item_valid  (item_valid),
		.item_pop    (item_pop)
	);

	kce_back #(.MAX_KEYS(MAX_KEYS), .FRAC_BITS(FRAC_BITS)) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item),
		.item_valid   (item_valid),
		.item_pop     (item_pop),
		.key_count    (key_count_q),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.curve_value  (curve_value),
		.segment_used (segment_used),
		.clamped      (clamped),
		.saturated    (saturated)
	);

endmodule
`default_nettype wire
